// ===== hw/rtl/fobc_pkg.sv =====
// Shared types, constants and round functions for the Feistel OFB byte cipher.
// No dependencies; imported by fobc_key_sched, fobc_feistel and the top level.
`timescale 1ns / 1ps

package fobc_pkg;

  localparam int NUM_ROUNDS_DEF = 8;

  // register indexes on the cfg channel
  localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
  localparam logic [1:0] REG_KEY_LOW     = 2'd1;
  localparam logic [1:0] REG_INIT_VECTOR = 2'd2;

  localparam logic [31:0] KEY_DELTA = 32'h9E37_79B9;
  localparam logic [31:0] SALT_BASE = 32'hA5A5_A5A5;
  localparam logic [31:0] SALT_STEP = 32'h0101_0101;

  localparam logic [3:0] SBOX4 [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  // Key schedule control
  typedef struct packed {
    logic load;   // take key words, reset round counters
    logic step;   // advance one expansion round
  } ks_ctl_t;

  // Block cipher control
  typedef struct packed {
    logic load_iv;  // halves from IV
    logic reload;   // feed previous output back in
    logic round;    // apply one round
  } fs_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] sub_nibbles(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 4] = SBOX4[v[4*k +: 4]];
    end
    return r;
  endfunction

  function automatic logic [31:0] mix_rot(input logic [31:0] v);
    return rotl(v, 5'd3) ^ rotl(v, 5'd11) ^ rotl(v, 5'd19);
  endfunction

endpackage

// ===== hw/rtl/fobc_key_ram.sv =====
// Round key memory: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module fobc_key_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fobc_key_sched.sv =====
// Key expansion datapath: one round key per step from a sliding 4-word window.
// Uses fobc_pkg (rotl, sub_nibbles, constants, ks_ctl_t).
`timescale 1ns / 1ps

module fobc_key_sched (
  input  logic              clk,
  input  fobc_pkg::ks_ctl_t ctl,
  input  logic [63:0]       key_high,
  input  logic [63:0]       key_low,
  output logic [31:0]       rk
);
  import fobc_pkg::*;

  logic [31:0] wa, wb, wc, wd;
  logic [31:0] delta;   // KEY_DELTA * (r + 1)
  logic [31:0] salt;    // SALT_BASE + r * SALT_STEP
  logic [2:0]  m7a;     // r % 7
  logic [2:0]  m7b;     // (r + 2) % 7
  logic [3:0]  m9;      // (r + 4) % 9

  logic [31:0] mix;
  logic [31:0] d_next;

  always_comb begin
    mix = rotl(wa ^ wc, {2'b00, m7a} + 5'd1)
        + rotl(wb ^ wd, {2'b00, m7b} + 5'd1)
        + delta;
    rk  = sub_nibbles(mix ^ rotl(wd, {1'b0, m9} + 5'd1));
    d_next = wa ^ rotl(rk, 5'd7) ^ salt;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      wa    <= key_high[63:32];
      wb    <= key_high[31:0];
      wc    <= key_low[63:32];
      wd    <= key_low[31:0];
      delta <= KEY_DELTA;
      salt  <= SALT_BASE;
      m7a   <= 3'd0;
      m7b   <= 3'd2;
      m9    <= 4'd4;
    end else if (ctl.step) begin
      wa    <= wb;
      wb    <= wc;
      wc    <= wd;
      wd    <= d_next;
      delta <= delta + KEY_DELTA;
      salt  <= salt + SALT_STEP;
      m7a   <= (m7a == 3'd6) ? 3'd0 : m7a + 3'd1;
      m7b   <= (m7b == 3'd6) ? 3'd0 : m7b + 3'd1;
      m9    <= (m9 == 4'd8) ? 4'd0 : m9 + 4'd1;
    end
  end

endmodule

// ===== hw/rtl/fobc_feistel.sv =====
// Iterated Feistel round unit; holds the feedback / keystream block.
// Uses fobc_pkg (sub_nibbles, mix_rot, fs_ctl_t).
`timescale 1ns / 1ps

module fobc_feistel (
  input  logic              clk,
  input  fobc_pkg::fs_ctl_t ctl,
  input  logic [63:0]       init_vector,
  input  logic [31:0]       rk,
  output logic [63:0]       blk
);
  import fobc_pkg::*;

  logic [31:0] lh, rh;

  // Halves swapped at output
  assign blk = {rh, lh};

  always_ff @(posedge clk) begin
    if (ctl.load_iv) begin
      lh <= init_vector[63:32];
      rh <= init_vector[31:0];
    end else if (ctl.reload) begin
      lh <= rh;
      rh <= lh;
    end else if (ctl.round) begin
      lh <= rh;
      rh <= lh ^ mix_rot(sub_nibbles(rh ^ rk));
    end
  end

endmodule

// ===== hw/rtl/feistel_ofb_byte_cipher.sv =====
// Top level: byte stream XOR with an OFB keystream from an 8-round Feistel cipher.
// Uses fobc_pkg, fobc_key_ram, fobc_key_sched, fobc_feistel.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     valid / stall             data_in, last_byte
// result    result_valid / result_stall  data_out, last_out
// config    cfg_valid / cfg_ready     cfg_index (0 key_high, 1 key_low, 2 init_vector), cfg_data
//
// A byte inside a keystream block is accepted, then XORed into the output register in S_EMIT.
// A byte that opens a block first passes S_PRIME and S_ENC: one round per cycle through the
// single round unit, fed by the one read port of the round key memory (registered read data).
// The first byte of a message first runs key expansion in S_KEY, one key written per cycle.
// Reset (rst, synchronous) clears the config registers, control state and the message flag.
// stall is high whenever an item is in flight; a held result never blocks acceptance, only
// the hand-off of the next one into the output register.

module feistel_ofb_byte_cipher #(
  parameter int NUM_ROUNDS = fobc_pkg::NUM_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  data_in,
  input  logic        last_byte,
  // result items
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  data_out,
  output logic        last_out,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import fobc_pkg::*;

  localparam int RW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  localparam logic [RW-1:0] LAST_RND = RW'(NUM_ROUNDS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,    // expand one round key per cycle into the memory
    S_PRIME,  // read key 0
    S_ENC,    // one cipher round per cycle
    S_EMIT    // XOR and hand to output register
  } state_t;

  state_t state;

  // configuration
  logic [63:0] key_high, key_low, init_vector;

  // per-item control
  logic [RW-1:0] rnd;
  logic [2:0]    byte_pos;
  logic          msg_start;
  logic [7:0]    din;
  logic          din_last;

  logic accept, emit_ok;
  logic [RW-1:0] raddr;
  logic [31:0]   rk_new, rk_rd;
  logic [63:0]   ks_blk;
  logic [7:0][7:0] ks_bytes;

  ks_ctl_t ks_ctl;
  fs_ctl_t fs_ctl;

  assign cfg_ready = 1'b1;
  assign stall     = (state != S_IDLE);
  assign accept    = valid && !stall;
  assign emit_ok   = !result_valid || !result_stall;
  assign ks_bytes  = ks_blk;

  // Key memory read address: key 0 when priming, next round's key while enciphering.
  // All writes finish in S_KEY before the first read, so no forwarding is needed.
  always_comb begin
    raddr = '0;
    if (state == S_ENC && rnd != LAST_RND) begin
      raddr = rnd + RW'(1);
    end
  end

  always_comb begin
    ks_ctl.load    = accept && msg_start;
    ks_ctl.step    = (state == S_KEY);
    fs_ctl.load_iv = accept && msg_start;
    fs_ctl.reload  = accept && !msg_start && (byte_pos == 3'd0);
    fs_ctl.round   = (state == S_ENC);
  end

  fobc_key_sched u_key_sched (
    .clk      (clk),
    .ctl      (ks_ctl),
    .key_high (key_high),
    .key_low  (key_low),
    .rk       (rk_new)
  );

  fobc_key_ram #(
    .DEPTH (NUM_ROUNDS),
    .AW    (RW)
  ) u_key_ram (
    .clk   (clk),
    .we    (state == S_KEY),
    .waddr (rnd),
    .wdata (rk_new),
    .raddr (raddr),
    .rdata (rk_rd)
  );

  fobc_feistel u_feistel (
    .clk         (clk),
    .ctl         (fs_ctl),
    .init_vector (init_vector),
    .rk          (rk_rd),
    .blk         (ks_blk)
  );

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high    <= '0;
      key_low     <= '0;
      init_vector <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_HIGH:    key_high    <= cfg_data;
        REG_KEY_LOW:     key_low     <= cfg_data;
        REG_INIT_VECTOR: init_vector <= cfg_data;
        default: ;
      endcase
    end
  end

  // held input byte
  always_ff @(posedge clk) begin
    if (accept) begin
      din      <= data_in;
      din_last <= last_byte;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_ok) begin
      data_out <= din ^ ks_bytes[3'd7 - byte_pos];
      last_out <= din_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rnd          <= '0;
      byte_pos     <= 3'd0;
      msg_start    <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && emit_ok) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rnd <= '0;
            if (msg_start) begin
              byte_pos  <= 3'd0;
              msg_start <= 1'b0;
              state     <= S_KEY;
            end else if (byte_pos == 3'd0) begin
              state <= S_PRIME;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_KEY: begin
          if (rnd == LAST_RND) begin
            rnd   <= '0;
            state <= S_PRIME;
          end else begin
            rnd <= rnd + RW'(1);
          end
        end
        S_PRIME: begin
          state <= S_ENC;
        end
        S_ENC: begin
          if (rnd == LAST_RND) begin
            rnd   <= '0;
            state <= S_EMIT;
          end else begin
            rnd <= rnd + RW'(1);
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            byte_pos <= byte_pos + 3'd1;
            if (din_last) begin
              msg_start <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  a_start_expands: assert property (@(posedge clk) disable iff (rst)
    (accept && msg_start) |=> (state == S_KEY && rnd == '0))
    else $error("message start did not begin key expansion");

  a_key_to_prime: assert property (@(posedge clk) disable iff (rst)
    (state == S_KEY && rnd == LAST_RND) |=> (state == S_PRIME))
    else $error("key expansion did not hand over to cipher");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_EMIT))
    else $error("result appeared outside emit");

  a_emit_block_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && accept && !msg_start && byte_pos == 3'd0) |=> (state == S_PRIME))
    else $error("block boundary skipped encipher");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for feistel_ofb_byte_cipher: OFB byte stream over an 8-round Feistel
// keystream. Depends only on the RTL (hw/rtl/fobc_pkg.sv, feistel_ofb_byte_cipher.sv + submodules).
`timescale 1ns / 1ps

module tb;
  import fobc_pkg::*;

  localparam int ROUNDS = 8;
  localparam int SETTLE_CYCLES = 4;  // extra idle cycles after the last result before a reg write

  // out of range register index, write must be dropped
  localparam logic [1:0] REG_NONE = 2'd3;

  // cipher constants, kept local to the predictor
  localparam logic [31:0] GOLDEN   = 32'h9E37_79B9;
  localparam logic [31:0] SALT     = 32'hA5A5_A5A5;
  localparam logic [31:0] SALT_INC = 32'h0101_0101;
  localparam logic [3:0]  NIB_SUB [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // ---------------------------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [7:0]  data_in = '0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  data_out;
  logic        last_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  feistel_ofb_byte_cipher #(
    .NUM_ROUNDS(ROUNDS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .stall        (stall),
    .data_in      (data_in),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .data_out     (data_out),
    .last_out     (last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------------
  // Predictor state: register shadows plus the cipher's own state, at reset values
  // ---------------------------------------------------------------------------------------------
  logic [63:0] key_high_shadow = '0;
  logic [63:0] key_low_shadow = '0;
  logic [63:0] iv_shadow = '0;
  logic [31:0] rkey_tab [ROUNDS];
  logic [63:0] feedback_blk = '0;
  logic [63:0] keystream_blk = '0;
  logic [2:0]  byte_pos = '0;
  logic        msg_open_pending = 1'b1;  // next byte starts a message

  byte_item_t pending_bytes [$];  // predicted output bytes, oldest first
  byte_item_t front_item;
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int hold_left = 0;   // long receiver hold-off, counted down by the receiver
  int stall_mode = 0;
  int mode_left = 0;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] nib_sub32(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 8; k++) r[4*k +: 4] = NIB_SUB[v[4*k +: 4]];
    return r;
  endfunction

  // Key schedule: four 32-bit words of the big-endian key rotate through a shift register,
  // each round key feeding the next word.
  function automatic void expand_round_keys();
    logic [31:0] a, b, c, d, m, nd;
    a = key_high_shadow[63:32];
    b = key_high_shadow[31:0];
    c = key_low_shadow[63:32];
    d = key_low_shadow[31:0];
    for (int r = 0; r < ROUNDS; r++) begin
      m = rol32(a ^ c, (r % 7) + 1) + rol32(b ^ d, ((r + 2) % 7) + 1) + GOLDEN * 32'(r + 1);
      rkey_tab[r] = nib_sub32(m ^ rol32(d, ((r + 4) % 9) + 1));
      nd = a ^ rol32(rkey_tab[r], 7) ^ (SALT + 32'(r) * SALT_INC);
      a = b;
      b = c;
      c = d;
      d = nd;
    end
  endfunction

  function automatic logic [63:0] feistel_encrypt(input logic [63:0] blk);
    logic [31:0] lh, rh, x, t;
    lh = blk[63:32];
    rh = blk[31:0];
    for (int r = 0; r < ROUNDS; r++) begin
      x = nib_sub32(rh ^ rkey_tab[r]);
      t = lh ^ rol32(x, 3) ^ rol32(x, 11) ^ rol32(x, 19);
      lh = rh;
      rh = t;
    end
    return {rh, lh};  // halves swapped at the output
  endfunction

  // One accepted byte in, one predicted output byte out.
  function automatic byte_item_t cipher_byte(input logic [7:0] d, input logic l);
    byte_item_t o;
    if (msg_open_pending) begin
      // key and IV are sampled here only, so writes inside a message wait for the next one
      expand_round_keys();
      feedback_blk = iv_shadow;
      byte_pos = '0;
      msg_open_pending = 1'b0;
    end
    if (byte_pos == 3'd0) begin
      keystream_blk = feistel_encrypt(feedback_blk);
      feedback_blk = keystream_blk;
    end
    o.data = d ^ keystream_blk[63 - 8*byte_pos -: 8];
    o.last = l;
    byte_pos = byte_pos + 3'd1;  // wraps after eight bytes
    if (l) msg_open_pending = 1'b1;  // a short final group just drops the rest of the block
    return o;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Receiver: checks each accepted result against the oldest prediction, then picks the next
  // stall value. Outputs are sampled right at the edge, before any of this edge's updates land.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: data_out %h last_out %b",
                   $realtime, data_out, last_out);
      end else begin
        front_item = pending_bytes.pop_front();
        if (data_out !== front_item.data || last_out !== front_item.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch data_out exp %h got %h, last_out exp %b got %b",
                     $realtime, front_item.data, data_out, front_item.last, last_out);
        end
      end
    end
    if (hold_left > 0) begin
      // long hold-off: the block has to fill up and stall its input
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      case (stall_mode)
        0: result_stall <= 1'b0;                          // free running
        1: result_stall <= ($urandom_range(0, 99) < 25);  // light
        2: result_stall <= ($urandom_range(0, 99) < 70);  // heavy
        default: result_stall <= ~result_stall;           // alternating
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Sender side. Every task is entered right after a rising edge and returns right after one.
  // ---------------------------------------------------------------------------------------------

  // Offers one item; works in bursts with random gaps in between.
  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    valid <= 1'b1;
    data_in <= d;
    last_byte <= l;
    @(posedge clk);
    while (stall) @(posedge clk);
    pending_bytes.push_back(cipher_byte(d, l));
    items_sent++;
  endtask

  // Sender pauses until every predicted byte has come out.
  task automatic drain();
    valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KEY_HIGH:    key_high_shadow = val;
      REG_KEY_LOW:     key_low_shadow = val;
      REG_INIT_VECTOR: iv_shadow = val;
      default: ;  // ignored by the block
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] kh, input logic [63:0] kl, input logic [63:0] iv);
    cfg_write(REG_KEY_HIGH, kh);
    cfg_write(REG_KEY_LOW, kl);
    cfg_write(REG_INIT_VECTOR, iv);
  endtask

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Loose stream: last flags at random, messages of any length.
  task automatic send_random_bytes(input int n);
    for (int i = 0; i < n; i++) send_byte(rand_data(), ($urandom_range(0, 7) == 0));
  endtask

  function automatic logic [63:0] phase_word(input int ph);
    case (ph)
      0: return '0;
      1: return '1;
      2: return 64'hAAAA_AAAA_AAAA_AAAA;
      3: return 64'h5555_5555_5555_5555;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------------

  // Reset values of all registers: zero key, zero IV. Short final group too.
  task automatic test_reset_config();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain();
  endtask

  // All-ones key and IV, a dropped out-of-range write, and a message crossing a block boundary.
  task automatic test_extreme_config();
    set_config('1, '1, '1);
    cfg_write(REG_NONE, {$urandom, $urandom});
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);  // first byte of the second block ends the message
    drain();
  endtask

  // New key and IV written in the middle of a message: the running message keeps the old ones,
  // the following single-byte message picks up the new ones.
  task automatic test_midmessage_rekey();
    set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_bytes(0);
    for (int i = 0; i < 4; i++) send_byte(rand_data(), 1'b0);
    drain();
    set_config({$urandom, $urandom}, '0, {$urandom, $urandom});
    for (int i = 0; i < 4; i++) send_byte(rand_data(), 1'b0);
    send_byte(rand_data(), 1'b1);
    send_byte(rand_data(), 1'b1);
    drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_output_holdoff();
    hold_left = 300;
    send_random_bytes(40);
    drain();
  endtask

  // Sender stops completely until all results are out, several times.
  task automatic test_sender_pause();
    for (int i = 0; i < 3; i++) begin
      send_random_bytes($urandom_range(10, 20));
      drain();
    end
  endtask

  // Phases of well-formed messages under different key settings, with occasional register
  // writes in mid-message (including out-of-range indexes).
  task automatic test_random_traffic();
    int phase_items;
    int len;
    int split;
    for (int ph = 0; ph < 8; ph++) begin
      set_config(phase_word(ph), phase_word((ph * 3) % 8), phase_word((ph * 5) % 8));
      phase_items = 0;
      while (phase_items < 55) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(41, 80);
          1, 2, 3,
          4, 5:    len = $urandom_range(17, 40);
          default: len = $urandom_range(1, 16);
        endcase
        split = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : 0;
        for (int i = 0; i < len; i++) begin
          if (split != 0 && i == split) begin
            drain();
            cfg_write(2'($urandom_range(0, 3)), {$urandom, $urandom});
          end
          send_byte(rand_data(), (i == len - 1));
        end
        phase_items += len;
      end
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_extreme_config();
    test_midmessage_rekey();
    test_output_holdoff();
    test_sender_pause();
    test_random_traffic();
    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: reports a failure and stops if the main sequence has not finished.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
